// File: rtl/core/lpm_pkg.sv
// Types, codes and constants shared by the latency percentile monitor
package lpm_pkg;

	typedef enum logic [1:0] {
		CMD_PLANNER  = 2'd0,
		CMD_EXECUTOR = 2'd1,
		CMD_QUERY    = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	localparam logic REG_DEADLINE = 1'b0;
	localparam logic REG_TARGET   = 1'b1;

	localparam logic [31:0] DEADLINE_RESET = 32'd700;
	localparam logic [31:0] TARGET_RESET   = 32'd600;
	localparam logic [6:0]  PCT_MAX        = 7'd100;

	// floor(x / 100) as (x * RECIP_MULT) >> RECIP_SHIFT, exact for x below 2**PROD_W
	localparam int               PROD_W      = 20;
	localparam logic [PROD_W-1:0] RECIP_MULT = 20'd671089;
	localparam int               RECIP_SHIFT = 26;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] sample;
		logic [31:0] qage;
		logic        wsel;
		logic [6:0]  pct;
	} item_t;

	typedef struct packed {
		logic [31:0] planner_peak;
		logic [31:0] executor_peak;
		logic [31:0] queue_age_peak;
		logic [31:0] planner_deadline_misses;
		logic [31:0] planner_target_misses;
		logic [31:0] executor_deadline_misses;
		logic [31:0] executor_target_misses;
		logic [31:0] queue_deadline_misses;
		logic [31:0] queue_target_misses;
	} stats_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RANK,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] c, input logic hit);
		return (hit && (c != 32'hFFFF_FFFF)) ? c + 32'd1 : c;
	endfunction

endpackage

// File: rtl/core/lpm_front.sv
// Input handshake, command decode and percent clamp
module lpm_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [31:0]        sample_us,
	input  logic [31:0]        queue_wait_us,
	input  logic               window_select,
	input  logic [6:0]         percent,
	input  logic               busy,
	input  logic               q_full,
	output logic               push,
	output lpm_pkg::item_t     item
);

	assign in_ready = !q_full && !busy;
	assign push     = in_valid && in_ready;

	always_comb begin
		item.cmd    = lpm_pkg::cmd_t'(command);
		item.sample = sample_us;
		item.qage   = queue_wait_us;
		item.wsel   = window_select;
		item.pct    = (percent > lpm_pkg::PCT_MAX) ? lpm_pkg::PCT_MAX : percent;
	end

endmodule

// File: rtl/core/lpm_queue.sv
// Two-entry item queue between front and back
module lpm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lpm_pkg::item_t push_item,
	input  logic           pop,
	output logic           q_valid,
	output logic           q_full,
	output lpm_pkg::item_t q_item
);

	lpm_pkg::item_t entry_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     level_q;

	assign q_valid = (level_q != 2'd0);
	assign q_full  = (level_q == 2'd2);
	assign q_item  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			level_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

// File: rtl/core/lpm_back.sv
// Window memories, statistics and bitwise rank selection
module lpm_back #(
	parameter int WINDOW_DEPTH = 512,
	parameter int AW = $clog2(WINDOW_DEPTH),
	parameter int CW = $clog2(WINDOW_DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [31:0]     deadline_q,
	input  logic [31:0]     target_q,
	input  logic            q_valid,
	input  lpm_pkg::item_t  q_item,
	output logic            pop,
	output logic            busy,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     percentile_value,
	output logic [CW-1:0]   sample_count,
	output lpm_pkg::stats_t stats
);

	lpm_pkg::state_t state_q, state_d;

	logic [31:0] pln_mem [WINDOW_DEPTH];
	logic [31:0] exe_mem [WINDOW_DEPTH];
	logic [31:0] pln_rd_s1;
	logic [31:0] exe_rd_s1;
	logic        vld_s1;

	logic [AW-1:0] clr_q;
	logic [AW-1:0] wi_q;
	logic [CW-1:0] fill_q;
	logic          out_valid_q;
	logic [31:0]   value_q;
	lpm_pkg::stats_t st_q;

	logic [lpm_pkg::PROD_W-1:0] prod_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [4:0]    bit_q;
	logic [31:0]   prefix_q;
	logic          wsel_q;

	logic          free;
	logic          is_query;
	logic          load_out;
	logic [31:0]   load_val;
	logic          rec_pln;
	logic          rec_exe;
	logic          pln_we;
	logic [AW-1:0] pln_wa;
	logic [31:0]   pln_wd;
	logic [AW-1:0] rd_addr;
	logic [31:0]   hi_mask;
	logic [31:0]   rd_word;
	logic          match;
	logic [2*lpm_pkg::PROD_W-1:0] scaled;
	logic [lpm_pkg::PROD_W-1:0]   nm1_ext;

	assign free      = !out_valid_q || out_ready;
	assign is_query  = (q_item.cmd == lpm_pkg::CMD_QUERY) && (fill_q != '0);
	assign busy      = (state_q == lpm_pkg::ST_CLEAR);
	assign rd_addr   = idx_q[AW-1:0];
	assign hi_mask   = 32'hFFFF_FFFF << ({1'b0, bit_q} + 6'd1);
	assign rd_word   = wsel_q ? exe_rd_s1 : pln_rd_s1;
	assign match     = (((rd_word ^ prefix_q) & hi_mask) == 32'd0) && !rd_word[bit_q];
	assign scaled    = (2*lpm_pkg::PROD_W)'(prod_q) * (2*lpm_pkg::PROD_W)'(lpm_pkg::RECIP_MULT);
	assign nm1_ext   = lpm_pkg::PROD_W'(fill_q - CW'(1));

	assign out_valid        = out_valid_q;
	assign percentile_value = value_q;
	assign sample_count     = fill_q;
	assign stats            = st_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpm_pkg::ST_CLEAR: begin
				if (clr_q == AW'(WINDOW_DEPTH - 1)) begin
					state_d = lpm_pkg::ST_IDLE;
				end
			end
			lpm_pkg::ST_IDLE: begin
				if (q_valid && is_query) begin
					state_d = lpm_pkg::ST_RANK;
				end
			end
			lpm_pkg::ST_RANK: state_d = lpm_pkg::ST_SCAN;
			lpm_pkg::ST_SCAN: begin
				if (idx_q == n_q - CW'(1)) begin
					state_d = lpm_pkg::ST_DRAIN;
				end
			end
			lpm_pkg::ST_DRAIN: state_d = lpm_pkg::ST_DECIDE;
			lpm_pkg::ST_DECIDE: begin
				state_d = (bit_q == 5'd0) ? lpm_pkg::ST_FINISH : lpm_pkg::ST_SCAN;
			end
			lpm_pkg::ST_FINISH: begin
				if (free) begin
					state_d = lpm_pkg::ST_IDLE;
				end
			end
			default: state_d = lpm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		load_val = 32'd0;
		rec_pln  = 1'b0;
		rec_exe  = 1'b0;
		unique case (state_q)
			lpm_pkg::ST_IDLE: begin
				pop      = q_valid && (is_query || free);
				load_out = q_valid && !is_query && free;
				rec_pln  = load_out && (q_item.cmd == lpm_pkg::CMD_PLANNER);
				rec_exe  = load_out && (q_item.cmd == lpm_pkg::CMD_EXECUTOR);
			end
			lpm_pkg::ST_FINISH: begin
				load_out = free;
				load_val = prefix_q;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
		pln_we = busy || rec_pln;
		pln_wa = busy ? clr_q : wi_q;
		pln_wd = busy ? 32'd0 : q_item.sample;
	end

	always_ff @(posedge clk) begin
		if (pln_we) begin
			pln_mem[pln_wa] <= pln_wd;
		end
		pln_rd_s1 <= pln_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (rec_exe) begin
			exe_mem[wi_q] <= q_item.sample;
		end
		exe_rd_s1 <= exe_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpm_pkg::ST_CLEAR;
			clr_q       <= '0;
			wi_q        <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
			st_q        <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == lpm_pkg::ST_SCAN);
			if (busy) begin
				clr_q <= clr_q + AW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (rec_pln) begin
				if (q_item.sample > st_q.planner_peak) begin
					st_q.planner_peak <= q_item.sample;
				end
				st_q.planner_deadline_misses <= lpm_pkg::sat_inc(
					st_q.planner_deadline_misses, q_item.sample > deadline_q);
				st_q.planner_target_misses <= lpm_pkg::sat_inc(
					st_q.planner_target_misses, q_item.sample > target_q);
			end
			if (rec_exe) begin
				if (q_item.sample > st_q.executor_peak) begin
					st_q.executor_peak <= q_item.sample;
				end
				if (q_item.qage > st_q.queue_age_peak) begin
					st_q.queue_age_peak <= q_item.qage;
				end
				st_q.executor_deadline_misses <= lpm_pkg::sat_inc(
					st_q.executor_deadline_misses, q_item.sample > deadline_q);
				st_q.executor_target_misses <= lpm_pkg::sat_inc(
					st_q.executor_target_misses, q_item.sample > target_q);
				st_q.queue_deadline_misses <= lpm_pkg::sat_inc(
					st_q.queue_deadline_misses, q_item.qage > deadline_q);
				st_q.queue_target_misses <= lpm_pkg::sat_inc(
					st_q.queue_target_misses, q_item.qage > target_q);
				wi_q <= (wi_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wi_q + AW'(1);
				if (fill_q < CW'(WINDOW_DEPTH)) begin
					fill_q <= fill_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			value_q <= load_val;
		end
		unique case (state_q)
			lpm_pkg::ST_IDLE: begin
				prod_q   <= nm1_ext * lpm_pkg::PROD_W'(q_item.pct);
				n_q      <= fill_q;
				wsel_q   <= q_item.wsel;
				bit_q    <= 5'd31;
				prefix_q <= 32'd0;
				idx_q    <= '0;
				cnt_q    <= '0;
			end
			lpm_pkg::ST_RANK: begin
				k_q <= scaled[lpm_pkg::RECIP_SHIFT +: CW];
			end
			lpm_pkg::ST_SCAN, lpm_pkg::ST_DRAIN: begin
				idx_q <= idx_q + CW'(1);
				if (vld_s1 && match) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			lpm_pkg::ST_DECIDE: begin
				if (k_q >= cnt_q) begin
					k_q      <= k_q - cnt_q;
					prefix_q <= prefix_q | (32'd1 << bit_q);
				end
				bit_q <= bit_q - 5'd1;
				idx_q <= '0;
				cnt_q <= '0;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

endmodule

// File: rtl/core/latency_percentile_monitor.sv
// Top level of the latency percentile monitor
//
//  channel | valid / ready        | payload
//  in      | in_valid / in_ready  | command, sample_us, queue_wait_us, window_select, percent
//  out     | out_valid / out_ready| percentile_value, sample_count, peaks, miss counters
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A record goes from input to output through the queue and then one back-end update.
// A query walks the window once per result bit with one memory read a cycle.
// After reset a clearing pass writes zeros to the planner window with in_ready low.
// The two-entry queue holds up to two items while the output stalls.
module latency_percentile_monitor #(
	parameter int WINDOW_DEPTH = 512,
	parameter int CW = $clog2(WINDOW_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    command,
	input  logic [31:0]   sample_us,
	input  logic [31:0]   queue_wait_us,
	input  logic          window_select,
	input  logic [6:0]    percent,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   percentile_value,
	output logic [CW-1:0] sample_count,
	output logic [31:0]   planner_peak,
	output logic [31:0]   executor_peak,
	output logic [31:0]   queue_age_peak,
	output logic [31:0]   planner_deadline_misses,
	output logic [31:0]   planner_target_misses,
	output logic [31:0]   executor_deadline_misses,
	output logic [31:0]   executor_target_misses,
	output logic [31:0]   queue_deadline_misses,
	output logic [31:0]   queue_target_misses,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_data
);

	logic            busy;
	logic            q_full;
	logic            q_valid;
	logic            push;
	logic            pop;
	lpm_pkg::item_t  push_item;
	lpm_pkg::item_t  q_item;
	lpm_pkg::stats_t stats;
	logic [31:0]     deadline_q;
	logic [31:0]     target_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadline_q <= lpm_pkg::DEADLINE_RESET;
			target_q   <= lpm_pkg::TARGET_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lpm_pkg::REG_DEADLINE: deadline_q <= cfg_data;
				lpm_pkg::REG_TARGET:   target_q   <= cfg_data;
				default:               deadline_q <= deadline_q;
			endcase
		end
	end

	lpm_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.sample_us     (sample_us),
		.queue_wait_us (queue_wait_us),
		.window_select (window_select),
		.percent       (percent),
		.busy          (busy),
		.q_full        (q_full),
		.push          (push),
		.item          (push_item)
	);

	lpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_full    (q_full),
		.q_item    (q_item)
	);

	lpm_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.CW           (CW)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.deadline_q       (deadline_q),
		.target_q         (target_q),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.pop              (pop),
		.busy             (busy),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.percentile_value (percentile_value),
		.sample_count     (sample_count),
		.stats            (stats)
	);

	assign planner_peak             = stats.planner_peak;
	assign executor_peak            = stats.executor_peak;
	assign queue_age_peak           = stats.queue_age_peak;
	assign planner_deadline_misses  = stats.planner_deadline_misses;
	assign planner_target_misses    = stats.planner_target_misses;
	assign executor_deadline_misses = stats.executor_deadline_misses;
	assign executor_target_misses   = stats.executor_target_misses;
	assign queue_deadline_misses    = stats.queue_deadline_misses;
	assign queue_target_misses      = stats.queue_target_misses;

`ifndef ASSERT_OFF
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("item pushed into a full queue");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sample_count <= CW'(WINDOW_DEPTH)) else $error("fill count beyond window");
	a_fill_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sample_count == CW'(WINDOW_DEPTH) |=> sample_count == CW'(WINDOW_DEPTH))
		else $error("full window count dropped");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_count == '0 |-> percentile_value == 32'd0)
		else $error("nonzero result with empty window");
`endif

endmodule
